// ----- src/b58_pkg.sv -----
// ----------------------------------------------------------------------------
// b58_pkg
// Shared types, constants and the character-to-digit map for the Base58
// decoder.
// ----------------------------------------------------------------------------
package b58_pkg;

   // Longest decoded message in bytes (1 to 64)
   localparam int MAX_BYTES = 32;
   // Counter wide enough to hold MAX_BYTES itself
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);
   localparam int ZC_W      = 7;
   localparam int TOT_W     = ZC_W + 1;
   localparam int DIGIT_W   = 6;
   localparam int CARRY_W   = 7;
   localparam int PROD_W    = 15;

   localparam logic [ZC_W-1:0] ZC_MAX    = '1;
   localparam logic [7:0]      LEAD_CHAR = 8'h31;   // '1'
   localparam logic [7:0]      RADIX     = 8'd58;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic [1:0] status;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic mul;
      logic clear;
   } acc_step_type;

   typedef enum logic [1:0] {
      RES_HOLD,
      RES_LOAD,
      RES_CARRY,
      RES_SHIFT
   } res_mode_type;

   typedef struct packed {
      logic [ZC_W-1:0] zero_count;
      logic            bad_char;
      logic            too_long;
   } msg_info_type;

   typedef struct packed {
      logic               valid;
      logic [DIGIT_W-1:0] value;
   } digit_type;

   // Alphabet 1-9 A-H J-N P-Z a-k m-z, digits 0..57
   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type  d;
      logic [7:0] diff;
      d    = '0;
      diff = 8'd0;
      d.valid = 1'b1;
      if (c >= 8'h31 && c <= 8'h39) begin
         diff = c - 8'h31;           // '1' -> 0
      end else if (c >= 8'h41 && c <= 8'h48) begin
         diff = c - 8'h38;           // 'A' -> 9
      end else if (c >= 8'h4A && c <= 8'h4E) begin
         diff = c - 8'h39;           // 'J' -> 17
      end else if (c >= 8'h50 && c <= 8'h5A) begin
         diff = c - 8'h3A;           // 'P' -> 22
      end else if (c >= 8'h61 && c <= 8'h6B) begin
         diff = c - 8'h40;           // 'a' -> 33
      end else if (c >= 8'h6D && c <= 8'h7A) begin
         diff = c - 8'h41;           // 'm' -> 44
      end else begin
         d.valid = 1'b0;
      end
      d.value = diff[DIGIT_W-1:0];
      return d;
   endfunction

endpackage

// ----- src/b58_acc_cell.sv -----
// ----------------------------------------------------------------------------
// b58_acc_cell
// One byte of the accumulator chain: multiply-by-58 and add with a carry
// that is registered and handed to the next cell up.
// ----------------------------------------------------------------------------
module b58_acc_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  b58_pkg::acc_step_type          step,
   input  logic [b58_pkg::DIGIT_W-1:0]    digit,
   input  logic [b58_pkg::CARRY_W-1:0]    cin,
   output logic [7:0]                     snap_a,
   output logic [b58_pkg::CARRY_W-1:0]    snap_c,
   output logic [b58_pkg::CARRY_W-1:0]    cout
);
   import b58_pkg::*;

   logic [7:0]         a_ff, a_in;
   logic [CARRY_W-1:0] cout_ff, cout_in;
   logic [8:0]         sum;
   logic [PROD_W-1:0]  t;

   // Pending carry is folded in before scaling; carry stays below 87
   always_comb begin
      sum = {1'b0, a_ff} + {2'b00, cin};
      if (step.mul) begin
         t = PROD_W'(sum) * PROD_W'(RADIX) + PROD_W'(digit);
      end else begin
         t = PROD_W'(sum);
      end
      snap_a  = t[7:0];
      snap_c  = t[PROD_W-1:8];
      a_in    = step.clear ? 8'd0 : snap_a;
      cout_in = step.clear ? '0 : snap_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff    <= 8'd0;
         cout_ff <= '0;
      end else begin
         a_ff    <= a_in;
         cout_ff <= cout_in;
      end
   end

   assign cout = cout_ff;

endmodule

// ----- src/b58_res_cell.sv -----
// ----------------------------------------------------------------------------
// b58_res_cell
// One byte of the resolve chain: settles leftover carries one step per
// cycle, then shifts bytes toward the top for output.
// ----------------------------------------------------------------------------
module b58_res_cell (
   input  logic                           clock,
   input  b58_pkg::res_mode_type          mode,
   input  logic [7:0]                     load_a,
   input  logic [b58_pkg::CARRY_W-1:0]    load_c,
   input  logic                           cin,
   input  logic [7:0]                     shift_in,
   output logic [7:0]                     a_out,
   output logic                           cout
);
   import b58_pkg::*;

   logic [7:0]         a_ff, a_in;
   logic [CARRY_W-1:0] c_ff, c_in;
   logic [8:0]         sum;

   always_comb begin
      sum  = {1'b0, a_ff} + {2'b00, c_ff};
      a_in = a_ff;
      c_in = c_ff;
      unique case (mode)
         RES_HOLD: begin
         end
         RES_LOAD: begin
            a_in = load_a;
            c_in = load_c;
         end
         RES_CARRY: begin
            a_in = sum[7:0];
            c_in = CARRY_W'(cin);
         end
         RES_SHIFT: begin
            a_in = shift_in;
            c_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      c_ff <= c_in;
   end

   assign a_out = a_ff;
   assign cout  = (mode == RES_CARRY) ? sum[8] : 1'b0;

endmodule

// ----- src/b58_emitter.sv -----
// ----------------------------------------------------------------------------
// b58_emitter
// Takes a finished message snapshot, settles carries, strips leading zero
// bytes and streams the result transactions through an output register.
// ----------------------------------------------------------------------------
module b58_emitter (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            load,
   input  b58_pkg::msg_info_type                           info,
   input  logic [b58_pkg::MAX_BYTES-1:0][7:0]              load_a,
   input  logic [b58_pkg::MAX_BYTES-1:0][b58_pkg::CARRY_W-1:0] load_c,
   output logic                                            busy,
   output logic                                            rsp_valid,
   input  logic                                            rsp_stall,
   output b58_pkg::rsp_type                                rsp_payload
);
   import b58_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CARRY,
      ST_STRIP,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   state_type           state_ff;
   msg_info_type        info_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    total_left_ff;
   logic [ZC_W-1:0]     zeros_left_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   res_mode_type        mode;
   logic [MAX_BYTES-1:0][7:0] cell_a;
   logic [MAX_BYTES-1:0]      cell_cout;
   logic [7:0]          top_a;
   logic                top_cout;
   logic                out_free;
   logic                strip_go;
   logic [CNT_W-1:0]    sig;
   logic [TOT_W-1:0]    total;
   logic                one_rsp;
   logic                rsp_load;

   for (genvar i = 0; i < MAX_BYTES; i++) begin : g_res
      logic       cin_w;
      logic [7:0] shift_w;
      if (i == 0) begin : g_bottom
         assign cin_w   = 1'b0;
         assign shift_w = 8'd0;
      end else begin : g_upper
         assign cin_w   = cell_cout[i-1];
         assign shift_w = cell_a[i-1];
      end
      b58_res_cell u_cell (
         .clock    (clock),
         .mode     (mode),
         .load_a   (load_a[i]),
         .load_c   (load_c[i]),
         .cin      (cin_w),
         .shift_in (shift_w),
         .a_out    (cell_a[i]),
         .cout     (cell_cout[i])
      );
   end

   assign top_a    = cell_a[MAX_BYTES-1];
   assign top_cout = cell_cout[MAX_BYTES-1];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign strip_go = (top_a == 8'd0) && (cnt_ff != CNT_W'(MAX_BYTES));
   assign sig      = CNT_W'(MAX_BYTES) - cnt_ff;
   assign total    = TOT_W'(info_ff.zero_count) + TOT_W'(sig);

   // Snapshot that ends in a single status transaction
   assign one_rsp  = info_ff.bad_char || info_ff.too_long ||
                     (total > TOT_W'(MAX_BYTES)) || (total == '0);
   assign rsp_load = out_free &&
                     ((state_ff == ST_EMIT) || ((state_ff == ST_DECIDE) && one_rsp));

   always_comb begin
      mode = RES_HOLD;
      unique case (state_ff)
         ST_IDLE:   if (load) mode = RES_LOAD;
         ST_CARRY:  mode = RES_CARRY;
         ST_STRIP:  if (strip_go) mode = RES_SHIFT;
         ST_DECIDE: mode = RES_HOLD;
         ST_EMIT:   if (out_free && zeros_left_ff == '0) mode = RES_SHIFT;
         default:   mode = RES_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (load) begin
                  info_ff  <= info;
                  cnt_ff   <= '0;
                  state_ff <= ST_CARRY;
               end
            end
            ST_CARRY: begin
               if (top_cout) begin
                  info_ff.too_long <= 1'b1;
               end
               if (cnt_ff == CNT_W'(MAX_BYTES - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_STRIP;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_STRIP: begin
               if (strip_go) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (out_free) begin
                  rsp_ff.data_byte <= 8'd0;
                  rsp_ff.has_byte  <= 1'b0;
                  rsp_ff.last_byte <= 1'b1;
                  priority if (info_ff.bad_char) begin
                     rsp_ff.status <= STATUS_BAD_CHAR;
                     state_ff      <= ST_IDLE;
                  end else if (info_ff.too_long || total > TOT_W'(MAX_BYTES)) begin
                     rsp_ff.status <= STATUS_TOO_LONG;
                     state_ff      <= ST_IDLE;
                  end else if (total == '0) begin
                     rsp_ff.status <= STATUS_OK;
                     state_ff      <= ST_IDLE;
                  end else begin
                     zeros_left_ff <= info_ff.zero_count;
                     total_left_ff <= total[CNT_W-1:0];
                     state_ff      <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_ff.has_byte  <= 1'b1;
                  rsp_ff.status    <= STATUS_OK;
                  rsp_ff.last_byte <= (total_left_ff == CNT_W'(1));
                  if (zeros_left_ff != '0) begin
                     rsp_ff.data_byte <= 8'd0;
                     zeros_left_ff    <= zeros_left_ff - 1'b1;
                  end else begin
                     rsp_ff.data_byte <= top_a;
                  end
                  total_left_ff <= total_left_ff - 1'b1;
                  if (total_left_ff == CNT_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> state_ff == ST_IDLE)
      else $error("snapshot loaded while emitter busy");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> total_left_ff != '0)
      else $error("emit state with no bytes left");

   a_zeros_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> CNT_W'(zeros_left_ff) <= total_left_ff)
      else $error("zero bytes exceed remaining total");

   a_nobyte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.has_byte |-> rsp_ff.last_byte)
      else $error("byteless transaction not marked last");
`endif

endmodule

// ----- src/base58_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base58_decoder_unit
// Streaming Base58 decoder: one character per request transaction, decoded
// bytes out most significant first, at most one byte per response transaction.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  req_      in   req_valid/req_stall  char_code[7:0], last_char
//  rsp_      out  rsp_valid/rsp_stall  data_byte[7:0], has_byte, status[1:0],
//                                      last_byte
//
//  Characters are taken one per cycle unless stalled; the accumulator is a
//  chain of MAX_BYTES byte cells with carries moving up one cell per cycle.
//  At a last character the chain state is copied to the emitter, which settles
//  carries, strips zero bytes and decides, then streams the
//  response transactions. A last character is stalled while the emitter still
//  drains the previous message; other characters are never stalled. rsp_stall
//  holds the output register and, while it is full, the emitter's decide and
//  emit steps. Synchronous reset returns to the start of a message.
// ----------------------------------------------------------------------------
module base58_decoder_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  b58_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output b58_pkg::rsp_type rsp_payload
);
   import b58_pkg::*;

   // Message front-end state
   logic            in_leading_ff;
   logic [ZC_W-1:0] zero_cnt_ff;
   logic            bad_ff;
   logic            too_long_ff;

   logic            accept;
   logic            lead_one;
   logic            ovf_now;
   logic            emit_busy;
   logic [ZC_W-1:0] zc_inc;
   digit_type       dig;
   acc_step_type    step;
   msg_info_type    info;

   logic [MAX_BYTES-1:0][7:0]         snap_a;
   logic [MAX_BYTES-1:0][CARRY_W-1:0] snap_c;
   logic [MAX_BYTES-1:0][CARRY_W-1:0] acc_cout;
   logic [MAX_BYTES-1:0][CARRY_W-1:0] res_load_c;

   // Only the closing character has to wait for the emitter
   assign req_stall = req_valid && req_payload.last_char && emit_busy;
   assign accept    = req_valid && !req_stall;

   assign dig      = digit_of(req_payload.char_code);
   assign lead_one = in_leading_ff && (req_payload.char_code == LEAD_CHAR);
   assign zc_inc   = (zero_cnt_ff == ZC_MAX) ? zero_cnt_ff : zero_cnt_ff + 1'b1;

   // Idle cycles still let carries ripple up the chain
   assign step.mul   = accept && !lead_one && dig.valid;
   assign step.clear = accept && req_payload.last_char;

   // Any carry leaving the top cell means the value no longer fits
   assign ovf_now = too_long_ff || (acc_cout[MAX_BYTES-1] != '0);

   for (genvar i = 0; i < MAX_BYTES; i++) begin : g_acc
      logic [CARRY_W-1:0] cin_w;
      logic [DIGIT_W-1:0] digit_w;
      if (i == 0) begin : g_bottom
         assign cin_w         = '0;
         assign digit_w       = dig.value;
         assign res_load_c[i] = '0;
      end else begin : g_upper
         assign cin_w         = acc_cout[i-1];
         assign digit_w       = '0;
         assign res_load_c[i] = snap_c[i-1];
      end
      b58_acc_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .step   (step),
         .digit  (digit_w),
         .cin    (cin_w),
         .snap_a (snap_a[i]),
         .snap_c (snap_c[i]),
         .cout   (acc_cout[i])
      );
   end

   // Snapshot of the message as the closing character lands
   always_comb begin
      info.zero_count = lead_one ? zc_inc : zero_cnt_ff;
      info.bad_char   = bad_ff || (!lead_one && !dig.valid);
      info.too_long   = ovf_now || (snap_c[MAX_BYTES-1] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset || step.clear) begin
         in_leading_ff <= 1'b1;
         zero_cnt_ff   <= '0;
         bad_ff        <= 1'b0;
         too_long_ff   <= 1'b0;
      end else begin
         too_long_ff <= ovf_now;
         if (accept) begin
            if (lead_one) begin
               zero_cnt_ff <= zc_inc;
            end else begin
               in_leading_ff <= 1'b0;
               if (!dig.valid) begin
                  bad_ff <= 1'b1;
               end
            end
         end
      end
   end

   b58_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .load        (step.clear),
      .info        (info),
      .load_a      (snap_a),
      .load_c      (res_load_c),
      .busy        (emit_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
